### design/rsa_pkg.sv
// ----------------------------------------------------------------------------
// rsa_pkg
// Shared types and constants for the reassembly slot allocator.
// ----------------------------------------------------------------------------
package rsa_pkg;

    localparam int SLOTS_DEFAULT = 16;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam int SLOT_W     = 4;
    localparam int PLATFORM_W = 3;
    localparam int ENTRY_W    = 8;

    typedef enum logic [0:0] {
        REG_LOCAL_PLATFORM = 1'b0,
        REG_NONE           = 1'b1
    } reg_index_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } state_t;

endpackage

### design/reassembly_slot_allocator_top.sv
// ----------------------------------------------------------------------------
// reassembly_slot_allocator_top
// Linked free-list allocator for message reassembly slots.
// ----------------------------------------------------------------------------
// A request raises busy in the cycle after start is taken. The next
// pointer of the list head is read from the next-pointer memory as start is
// taken, and the pointer write-back and head update happen at the end of the
// busy cycle. The result is shown for exactly one cycle, marked by done, in
// the cycle after busy, as busy falls; the receiver cannot stall it, and a new
// request may be started in that same cycle. The next-pointer memory needs no
// clearing pass after reset, as one valid bit per slot stands in for its
// initial contents.
// ----------------------------------------------------------------------------
module reassembly_slot_allocator_top #(
    parameter int SLOTS = rsa_pkg::SLOTS_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                first_fragment,
    input  logic [rsa_pkg::SLOT_W-1:0]          slot_in,
    input  logic [rsa_pkg::PLATFORM_W-1:0]      sender_platform,
    input  logic [rsa_pkg::ENTRY_W-1:0]         sender_entry,
    input  logic                                last_fragment,
    output logic                                done,
    output logic [rsa_pkg::SLOT_W-1:0]          slot_out,
    output logic                                signal_sender,
    output logic [rsa_pkg::ENTRY_W-1:0]         sender_entry_out,
    output logic                                message_complete,
    output logic                                status,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [rsa_pkg::CFG_ADDR_W-1:0]      paddr,
    input  logic [rsa_pkg::CFG_DATA_W-1:0]      pwdata,
    output logic [rsa_pkg::CFG_DATA_W-1:0]      prdata,
    output logic                                pready
);

    localparam int SW = $clog2(SLOTS);
    localparam int PW = $clog2(SLOTS + 1);

    rsa_pkg::state_t                     state_reg;
    rsa_pkg::state_t                     state_next;
    logic [PW-1:0]                       head_reg;
    logic [PW-1:0]                       head_next;
    logic [SLOTS-1:0]                    valid_reg;
    logic [PW-1:0]                       mem [SLOTS];
    logic [PW-1:0]                       rd_data_reg;
    logic [rsa_pkg::PLATFORM_W-1:0]      local_platform_reg;

    logic                                first_reg;
    logic [rsa_pkg::SLOT_W-1:0]          slot_in_reg;
    logic [rsa_pkg::PLATFORM_W-1:0]      sender_reg;
    logic [rsa_pkg::ENTRY_W-1:0]         entry_reg;
    logic                                last_reg;

    logic                                done_reg;
    logic [rsa_pkg::SLOT_W-1:0]          slot_out_reg;
    logic                                signal_reg;
    logic [rsa_pkg::ENTRY_W-1:0]         entry_out_reg;
    logic                                complete_reg;
    logic                                status_reg;

    logic                                accept;
    logic                                exec;
    logic [SW-1:0]                       rd_addr;
    logic [PW-1:0]                       rd_init;
    logic                                empty;
    logic                                dropped;
    logic [SW-1:0]                       slot_sel;
    logic [PW-1:0]                       head_popped;
    logic                                wr_en;
    logic                                cfg_wr;
    rsa_pkg::reg_index_t                 cfg_index;

    function automatic logic [SW-1:0] slot_wrap(input logic [rsa_pkg::SLOT_W-1:0] raw);
        logic [8:0] v;
        v = 9'(raw);
        for (int i = 0; i < 8; i++) begin
            if (v >= 9'(SLOTS))
            begin
                v = v - 9'(SLOTS);
            end
        end
        return SW'(v);
    endfunction

    assign accept = start && (state_reg == rsa_pkg::ST_IDLE);
    assign exec   = (state_reg == rsa_pkg::ST_EXEC);
    assign busy   = exec;

    assign rd_addr = head_reg[SW-1:0];
    assign rd_init = PW'(rd_addr) + PW'(1);

    assign empty       = (head_reg >= PW'(SLOTS));
    assign dropped     = first_reg && empty;
    assign slot_sel    = first_reg ? head_reg[SW-1:0] : slot_wrap(slot_in_reg);
    assign head_popped = first_reg ? rd_data_reg : head_reg;
    assign wr_en       = exec && !dropped && last_reg;

    always_comb
    begin
        state_next = state_reg;
        head_next  = head_reg;
        case (state_reg)
            rsa_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = rsa_pkg::ST_EXEC;
                end
            end
            rsa_pkg::ST_EXEC:
            begin
                state_next = rsa_pkg::ST_IDLE;
                if (!dropped)
                begin
                    head_next = last_reg ? PW'(slot_sel) : head_popped;
                end
            end
            default:
            begin
                state_next = rsa_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rsa_pkg::ST_IDLE;
            head_reg  <= '0;
            valid_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            done_reg  <= exec;
            if (wr_en)
            begin
                valid_reg[slot_sel] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[slot_sel] <= head_popped;
        end
        if (accept)
        begin
            rd_data_reg <= valid_reg[rd_addr] ? mem[rd_addr] : rd_init;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            first_reg   <= first_fragment;
            slot_in_reg <= slot_in;
            sender_reg  <= sender_platform;
            entry_reg   <= sender_entry;
            last_reg    <= last_fragment;
        end
        if (exec)
        begin
            slot_out_reg  <= dropped ? '0 : rsa_pkg::SLOT_W'(slot_sel);
            signal_reg    <= !dropped && (sender_reg == local_platform_reg);
            entry_out_reg <= entry_reg;
            complete_reg  <= !dropped && last_reg;
            status_reg    <= dropped;
        end
    end

    assign cfg_wr    = psel && penable && pwrite && pready;
    assign cfg_index = rsa_pkg::reg_index_t'(paddr[rsa_pkg::CFG_ADDR_W-1]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            local_platform_reg <= '0;
        end
        else if (cfg_wr && (cfg_index == rsa_pkg::REG_LOCAL_PLATFORM))
        begin
            local_platform_reg <= pwdata[rsa_pkg::PLATFORM_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        case (cfg_index)
            rsa_pkg::REG_LOCAL_PLATFORM:
            begin
                prdata = rsa_pkg::CFG_DATA_W'(local_platform_reg);
            end
            default:
            begin
                prdata = '0;
            end
        endcase
    end

    assign pready = 1'b1;

    assign done             = done_reg;
    assign slot_out         = slot_out_reg;
    assign signal_sender    = signal_reg;
    assign sender_entry_out = entry_out_reg;
    assign message_complete = complete_reg;
    assign status           = status_reg;

endmodule

### design/rsa_checker.sv
// ----------------------------------------------------------------------------
// rsa_checker
// Port-level checks on the request and result timing of the allocator.
// ----------------------------------------------------------------------------
module rsa_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           start,
    input logic                           busy,
    input logic                           done,
    input logic [rsa_pkg::SLOT_W-1:0]     slot_out,
    input logic                           signal_sender,
    input logic                           message_complete,
    input logic                           status
);

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not raise busy");

    a_busy_single: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> (!busy && done))
        else $error("busy did not end with a result");

    a_done_follows_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (!busy && $past(busy)))
        else $error("result strobe without a preceding request");

    a_drop_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status) |-> (slot_out == '0 && !signal_sender && !message_complete))
        else $error("dropped request carried result fields");

endmodule

bind reassembly_slot_allocator_top rsa_checker u_rsa_checker (.*);

### dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the reassembly slot allocator.
//
// Fragment requests are queued by a stimulus process and presented by a
// clocked driver with random gaps. Each accepted request is run through a
// free-list model in the bench, and the one-cycle results are checked field
// by field as they appear. The local platform register is rewritten and read
// back between phases while the block is idle. A short directed set empties
// the list and frees slots. Random phases of mostly well-formed messages
// follow, and the last phase adds double frees and other broken sequences.
// ----------------------------------------------------------------------------
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS       = rsa_pkg::SLOTS_DEFAULT;
    localparam int SLOT_W      = rsa_pkg::SLOT_W;
    localparam int PLATFORM_W  = rsa_pkg::PLATFORM_W;
    localparam int ENTRY_W     = rsa_pkg::ENTRY_W;
    localparam int CFG_ADDR_W  = rsa_pkg::CFG_ADDR_W;
    localparam int CFG_DATA_W  = rsa_pkg::CFG_DATA_W;
    localparam int PTR_W       = SLOT_W + 1;
    localparam int STALL_LIMIT = 2000;

    typedef struct packed {
        logic                  first;
        logic [SLOT_W-1:0]     slot;
        logic [PLATFORM_W-1:0] sender;
        logic [ENTRY_W-1:0]    entry;
        logic                  last;
    } fragment_t;

    typedef struct packed {
        logic [SLOT_W-1:0]  slot;
        logic               notify;
        logic [ENTRY_W-1:0] entry;
        logic               complete;
        logic               status;
    } outcome_t;

    typedef struct packed {
        logic [SLOTS-1:0][PTR_W-1:0] next_slot;
        logic [PTR_W-1:0]            free_head;
    } free_list_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    logic                  done;
    fragment_t             drv = '0;
    logic [SLOT_W-1:0]     slot_out;
    logic                  signal_sender;
    logic [ENTRY_W-1:0]    sender_entry_out;
    logic                  message_complete;
    logic                  status;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [CFG_DATA_W-1:0] pwdata = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    fragment_t             pending_q[$];
    outcome_t              expected_q[$];
    free_list_t            model_list;
    free_list_t            plan_list;
    logic [SLOTS-1:0]      open_slots;
    logic [PLATFORM_W-1:0] platform_id = '0;
    outcome_t              want;
    bit                    quiet = 1'b0;
    int                    gap_left = 0;
    int                    idle_cycles = 0;
    int                    n_sent = 0;
    int                    n_results = 0;
    int                    n_dropped = 0;
    int                    n_writes = 0;
    int                    n_errors = 0;

    always #10 clk = ~clk;

    reassembly_slot_allocator_top #(
        .SLOTS(SLOTS)
    ) dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .first_fragment   (drv.first),
        .slot_in          (drv.slot),
        .sender_platform  (drv.sender),
        .sender_entry     (drv.entry),
        .last_fragment    (drv.last),
        .done             (done),
        .slot_out         (slot_out),
        .signal_sender    (signal_sender),
        .sender_entry_out (sender_entry_out),
        .message_complete (message_complete),
        .status           (status),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    function automatic free_list_t fresh_free_list();
        free_list_t fl;
        for (int i = 0; i < SLOTS; i++)
        begin
            fl.next_slot[i] = PTR_W'(i + 1);
        end
        fl.free_head = '0;
        return fl;
    endfunction

    // Pops the head for a first fragment (dropped if the list is empty), pushes the slot back on a last one.
    function automatic outcome_t allocate_slot(inout free_list_t fl, input fragment_t f,
                                               input logic [PLATFORM_W-1:0] local_id);
        outcome_t o;
        int       slot;
        o       = '0;
        o.entry = f.entry;
        if (f.first && fl.free_head >= SLOTS)
        begin
            o.status = 1'b1;
        end
        else
        begin
            if (f.first)
            begin
                slot         = int'(fl.free_head);
                fl.free_head = fl.next_slot[slot];
            end
            else
            begin
                slot = int'(f.slot) % SLOTS;
            end
            o.slot     = SLOT_W'(slot);
            o.notify   = (f.sender == local_id);
            o.complete = f.last;
            if (f.last)
            begin
                fl.next_slot[slot] = fl.free_head;
                fl.free_head       = PTR_W'(slot);
            end
        end
        return o;
    endfunction

    function automatic fragment_t frag(input logic first, input logic [SLOT_W-1:0] slot,
                                       input logic [PLATFORM_W-1:0] sender,
                                       input logic [ENTRY_W-1:0] entry, input logic last);
        fragment_t f;
        f.first  = first;
        f.slot   = slot;
        f.sender = sender;
        f.entry  = entry;
        f.last   = last;
        return f;
    endfunction

    function automatic int pick_open_slot();
        int s;
        do
        begin
            s = $urandom_range(0, SLOTS - 1);
        end
        while (!open_slots[s]);
        return s;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint exp_val);
        $display("MISMATCH %s: got %0d, expected %0d (result %0d)", what, got, exp_val,
                 n_results);
        n_errors++;
    endtask

    task automatic queue_fragment(input fragment_t f);
        outcome_t o;
        o = allocate_slot(plan_list, f, '0);
        if (!o.status)
        begin
            if (f.last)
            begin
                open_slots[o.slot] = 1'b0;
            end
            else if (f.first)
            begin
                open_slots[o.slot] = 1'b1;
            end
        end
        pending_q.push_back(f);
    endtask

    task automatic plan_phase(input int count, input int first_pct, input int noise_pct,
                              input bit wild);
        fragment_t f;
        repeat (count)
        begin
            f.sender = PLATFORM_W'($urandom_range(0, 7));
            f.entry  = ENTRY_W'($urandom_range(0, 255));
            f.slot   = SLOT_W'($urandom_range(0, SLOTS - 1));
            if ($urandom_range(0, 99) < noise_pct)
            begin
                f.first = 1'($urandom_range(0, 1));
                f.last  = 1'($urandom_range(0, 1));
                if (!wild && !f.first && !open_slots[f.slot])
                begin
                    f.last = 1'b0;
                end
            end
            else if (open_slots == '0 || $urandom_range(0, 99) < first_pct)
            begin
                f.first = 1'b1;
                f.last  = ($urandom_range(0, 3) == 0);
            end
            else
            begin
                f.first = 1'b0;
                f.slot  = SLOT_W'(pick_open_slot());
                f.last  = ($urandom_range(0, 2) == 0);
            end
            queue_fragment(f);
        end
    endtask

    task automatic write_local_platform(input logic [PLATFORM_W-1:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CFG_ADDR_W'(4 * int'(rsa_pkg::REG_LOCAL_PLATFORM));
        pwdata  <= CFG_DATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!pready);
        platform_id = value;
        n_writes++;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!pready);
        if (prdata !== CFG_DATA_W'(value))
        begin
            report_mismatch("local_platform readback", longint'(prdata), longint'(value));
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
    endtask

    task automatic drain();
        while (pending_q.size() != 0 || start || expected_q.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (4) @(negedge clk);
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
            begin
                expected_q.push_back(allocate_slot(model_list, drv, platform_id));
                n_sent++;
            end
            if (!start || !busy)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    start <= 1'b0;
                end
                else if (pending_q.size() != 0 && !quiet && $urandom_range(0, 4) == 0)
                begin
                    gap_left = $urandom_range(0, 2);
                    start <= 1'b0;
                end
                else if (pending_q.size() != 0)
                begin
                    drv   <= pending_q.pop_front();
                    start <= 1'b1;
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_q.size() == 0)
            begin
                report_mismatch("result with no request outstanding, slot_out",
                                longint'(slot_out), longint'(0));
            end
            else
            begin
                want = expected_q.pop_front();
                if (slot_out !== want.slot)
                begin
                    report_mismatch("slot_out", longint'(slot_out), longint'(want.slot));
                end
                if (signal_sender !== want.notify)
                begin
                    report_mismatch("signal_sender", longint'(signal_sender),
                                    longint'(want.notify));
                end
                if (sender_entry_out !== want.entry)
                begin
                    report_mismatch("sender_entry_out", longint'(sender_entry_out),
                                    longint'(want.entry));
                end
                if (message_complete !== want.complete)
                begin
                    report_mismatch("message_complete", longint'(message_complete),
                                    longint'(want.complete));
                end
                if (status !== want.status)
                begin
                    report_mismatch("status", longint'(status), longint'(want.status));
                end
                if (want.status)
                begin
                    n_dropped++;
                end
                n_results++;
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done || (psel && penable && pready))
        begin
            idle_cycles = 0;
        end
        else
        begin
            idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("Timed out after %0d cycles without progress.", idle_cycles);
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    initial
    begin
        int s;
        model_list = fresh_free_list();
        plan_list  = fresh_free_list();
        open_slots = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        write_local_platform('0);
        for (int i = 0; i < SLOTS; i++)
        begin
            queue_fragment(frag(1'b1, i[0] ? 4'hF : 4'h0, PLATFORM_W'(i),
                                (i == 0) ? 8'h00 : (i == 1) ? 8'hFF : i[0] ? 8'hAA : 8'h55,
                                1'b0));
        end
        queue_fragment(frag(1'b1, 4'h0, 3'd0, 8'h12, 1'b0));
        queue_fragment(frag(1'b1, 4'hF, 3'd7, 8'hED, 1'b1));
        queue_fragment(frag(1'b0, 4'hF, 3'd0, 8'h01, 1'b1));
        queue_fragment(frag(1'b0, 4'h0, 3'd3, 8'h80, 1'b0));
        queue_fragment(frag(1'b0, 4'h0, 3'd3, 8'h7F, 1'b1));
        queue_fragment(frag(1'b1, 4'hA, 3'd5, 8'h3C, 1'b1));
        queue_fragment(frag(1'b0, 4'h5, 3'd2, 8'hC3, 1'b0));
        drain();

        write_local_platform(3'd7);
        plan_phase(110, 50, 10, 1'b0);
        drain();

        write_local_platform(PLATFORM_W'($urandom_range(1, 6)));
        plan_phase(100, 85, 10, 1'b0);
        drain();

        write_local_platform(3'd3);
        plan_phase(100, 30, 10, 1'b0);
        drain();

        // A double free turns the list into a loop for good, so it comes last.
        write_local_platform(PLATFORM_W'($urandom_range(0, 7)));
        quiet = 1'b1;
        if (open_slots == '0)
        begin
            queue_fragment(frag(1'b1, 4'h9, 3'd1, 8'h99, 1'b0));
        end
        s = pick_open_slot();
        queue_fragment(frag(1'b0, SLOT_W'(s), 3'd4, 8'h66, 1'b1));
        queue_fragment(frag(1'b0, SLOT_W'(s), 3'd4, 8'h99, 1'b1));
        plan_phase(110, 50, 30, 1'b1);
        drain();

        $display("Sent %0d fragment requests and checked %0d results over %0d register writes.",
                 n_sent, n_results, n_writes);
        $display("%0d first fragments found the free list empty and were dropped.", n_dropped);
        if (n_errors == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
